// ===== sv/mmr_pkg.sv =====
package mmr_pkg;

  // Field widths of the transactions and the configuration registers.
  localparam int ActionW   = 2;
  localparam int ElemIdxW  = 6;
  localparam int ElemW     = 16;
  localparam int PosW      = 6;
  localparam int ProdW     = 35;
  localparam int SizeW     = 4;
  localparam int RangeW    = 7;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 7;
  localparam int MulW      = 2 * ElemW;

  // Action codes of an input transaction.
  localparam logic [ActionW-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ActionW-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ActionW-1:0] ACT_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MATRIX_SIZE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_POSITION = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_POSITION   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SizeW-1:0]  SIZE_RST  = 4'd8;
  localparam logic [RangeW-1:0] FIRST_RST = 7'd0;
  localparam logic [RangeW-1:0] END_RST   = 7'd64;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_SEND  = 5'b10000
  } state_t;

endpackage

// ===== sv/mmr_if.sv =====
interface mmr_in_if
  import mmr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [ActionW-1:0]         action;
  logic [ElemIdxW-1:0]        element_index;
  logic signed [ElemW-1:0]    element_value;

  modport source (output valid, action, element_index, element_value, input ready);
  modport sink   (input valid, action, element_index, element_value, output ready);
endinterface

interface mmr_out_if
  import mmr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [PosW-1:0]            position;
  logic signed [ProdW-1:0]    product_value;
  logic                       last_result;

  modport source (output valid, position, product_value, last_result, input ready);
  modport sink   (input valid, position, product_value, last_result, output ready);
endinterface

// ===== sv/matrix_multiply_range_top.sv =====
// Square matrix multiply over a range of row-major output positions.
// The input channel in_ch carries one transaction per command. A load of A or
// B writes one signed Q8.8 element into its store, so loads stream at one per
// cycle while no compute runs; an index at or beyond n*n is dropped.
// A compute transaction emits one result on out_ch for each position from
// first_position up to end_position clipped to n*n, each the exact signed
// Q16.16 dot product of a row of A with a column of B; the final result
// carries last_result. An empty range or a size of zero emits nothing.
// While a compute runs, in_ch.ready stays low. One multiplier and one
// accumulator are shared: per position the sequencer locates row and column,
// issues the reads of the n terms, waits while the last term passes the
// read and multiply stages and then presents the result. Before the first
// position the row is found by repeated subtraction. If the receiver stalls,
// the result register holds its transaction and the sequencer waits.
// Reset (rst_n low, synchronous) returns to idle, drops any pending result
// and restores the configuration; the element stores are not cleared.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
module matrix_multiply_range_top
  import mmr_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mmr_in_if.sink               in_ch,
  mmr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int MemAw = (Depth > 1) ? $clog2(Depth) : 1;

  // Configuration registers.
  logic [SizeW-1:0]  matrix_size_r;
  logic [RangeW-1:0] first_position_r;
  logic [RangeW-1:0] end_position_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r    <= SIZE_RST;
      first_position_r <= FIRST_RST;
      end_position_r   <= END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATRIX_SIZE:    matrix_size_r    <= cfg_data[SizeW-1:0];
        CFG_FIRST_POSITION: first_position_r <= cfg_data[RangeW-1:0];
        CFG_END_POSITION:   end_position_r   <= cfg_data[RangeW-1:0];
        default: ;
      endcase
    end
  end

  // Size in use saturates at the store dimension; total is n squared.
  logic [SizeW-1:0]  n;
  logic [RangeW-1:0] n_ext;
  logic [RangeW-1:0] total;
  logic [RangeW-1:0] stop;

  assign n     = (matrix_size_r > SizeW'(MAX_DIM)) ? SizeW'(MAX_DIM) : matrix_size_r;
  assign n_ext = RangeW'(n);
  assign total = n_ext * n_ext;
  assign stop  = (end_position_r < total) ? end_position_r : total;

  // Sequencer registers.
  state_t             state_r;
  logic [RangeW-1:0]  pos_r;
  logic [RangeW-1:0]  stop_r;
  logic [RangeW-1:0]  row_base_r;
  logic [RangeW-1:0]  col_r;
  logic [SizeW-1:0]   k_r;
  logic [RangeW-1:0]  a_addr_r;
  logic [RangeW-1:0]  b_addr_r;

  logic in_accept;
  logic cmd_load_a;
  logic cmd_load_b;
  logic load_ok;
  logic issue;
  logic issue_last;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign load_ok     = {1'b0, in_ch.element_index} < total;
  assign cmd_load_a  = in_accept && (in_ch.action == ACT_LOAD_A) && load_ok;
  assign cmd_load_b  = in_accept && (in_ch.action == ACT_LOAD_B) && load_ok;
  assign issue       = (state_r == ST_MAC);
  assign issue_last  = issue && (k_r == n - SizeW'(1));

  // Element stores with registered reads.
  logic signed [ElemW-1:0] mem_a [Depth];
  logic signed [ElemW-1:0] mem_b [Depth];
  logic signed [ElemW-1:0] a_rd_r;
  logic signed [ElemW-1:0] b_rd_r;

  always_ff @(posedge clk) begin
    if (cmd_load_a) begin
      mem_a[in_ch.element_index[MemAw-1:0]] <= in_ch.element_value;
    end
    a_rd_r <= mem_a[a_addr_r[MemAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd_load_b) begin
      mem_b[in_ch.element_index[MemAw-1:0]] <= in_ch.element_value;
    end
    b_rd_r <= mem_b[b_addr_r[MemAw-1:0]];
  end

  // Read, multiply and accumulate stages.
  logic                    rd_vld_r;
  logic                    rd_last_r;
  logic                    prod_vld_r;
  logic                    prod_last_r;
  logic signed [MulW-1:0]  prod_r;
  logic signed [ProdW-1:0] acc_r;
  logic signed [ProdW-1:0] acc_nxt;

  assign acc_nxt = acc_r + ProdW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      prod_vld_r  <= 1'b0;
      prod_last_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      rd_vld_r    <= issue;
      rd_last_r   <= issue_last;
      prod_vld_r  <= rd_vld_r;
      prod_last_r <= rd_last_r;
      if (prod_vld_r) begin
        // The sum restarts after the last term of each position.
        acc_r <= prod_last_r ? '0 : acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
  end

  // Result register.
  logic                    out_valid_r;
  logic [PosW-1:0]         out_pos_r;
  logic signed [ProdW-1:0] out_value_r;
  logic                    out_last_r;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = out_pos_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.last_result   = out_last_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_DRAIN && prod_vld_r && prod_last_r) begin
      out_pos_r   <= pos_r[PosW-1:0];
      out_value_r <= acc_nxt;
      out_last_r  <= (pos_r + RangeW'(1)) == stop_r;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept && in_ch.action == ACT_COMPUTE && n != '0 &&
              first_position_r < stop) begin
            stop_r     <= stop;
            pos_r      <= first_position_r;
            col_r      <= first_position_r;
            row_base_r <= '0;
            state_r    <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Reduce the column below n, moving the row base along.
          if (col_r >= n_ext) begin
            col_r      <= col_r - n_ext;
            row_base_r <= row_base_r + n_ext;
          end else begin
            a_addr_r <= row_base_r;
            b_addr_r <= col_r;
            k_r      <= '0;
            state_r  <= ST_MAC;
          end
        end
        ST_MAC: begin
          a_addr_r <= a_addr_r + RangeW'(1);
          b_addr_r <= b_addr_r + n_ext;
          k_r      <= k_r + SizeW'(1);
          if (issue_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (prod_vld_r && prod_last_r) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= ST_IDLE;
            end else begin
              pos_r   <= pos_r + RangeW'(1);
              col_r   <= col_r + RangeW'(1);
              state_r <= ST_DIV;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
